@@ sv/sensor_poll_supervisor_macros.svh @@
// assertion macros used by the sensor poll supervisor top level
`ifndef SENSOR_POLL_SUPERVISOR_MACROS_SVH
`define SENSOR_POLL_SUPERVISOR_MACROS_SVH

// checked while out of reset
`define SPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define SPS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/sps_pkg.sv @@
// types and constants shared by the sensor poll supervisor
`default_nettype none
package sps_pkg;

  localparam int unsigned StampW = 32;
  localparam int unsigned TempW  = 12;
  localparam int unsigned CountW = 8;
  localparam int unsigned IntvW  = 16;

  localparam logic signed [TempW-1:0] TEMP_LOW_LIMIT  = -12'sd880;
  localparam logic signed [TempW-1:0] TEMP_HIGH_LIMIT = 12'sd2000;
  localparam logic [CountW-1:0]       ERROR_CEILING   = 8'hFF;

  localparam logic [IntvW-1:0]  READ_INTERVAL_RST = 16'd2000;
  localparam logic [IntvW-1:0]  CONVERSION_RST    = 16'd750;
  localparam logic [CountW-1:0] MAX_ERRORS_RST    = 8'd3;

  typedef struct packed {
    logic [StampW-1:0]       now_ms;
    logic                    probe_found;
    logic [CountW-1:0]       probe_count;
    logic signed [TempW-1:0] sample_value;
    logic                    take_changed;
  } in_word_t;

  typedef struct packed {
    logic                    start_conversion;
    logic                    probe_used;
    logic                    sample_used;
    logic signed [TempW-1:0] temperature;
    logic                    reading_valid;
    logic                    changed_taken;
    logic [CountW-1:0]       error_total;
    logic [CountW-1:0]       device_total;
    logic                    converting;
  } out_word_t;

  typedef struct packed {
    logic [IntvW-1:0]  read_interval_ms;
    logic [IntvW-1:0]  conversion_ms;
    logic [CountW-1:0] max_errors;
  } sps_cfg_t;

  typedef struct packed {
    logic                    converting;
    logic                    device_known;
    logic                    first_due;
    logic [StampW-1:0]       last_read_stamp;
    logic [StampW-1:0]       conversion_stamp;
    logic signed [TempW-1:0] held_temperature;
    logic                    valid_flag;
    logic                    changed_flag;
    logic [CountW-1:0]       error_counter;
    logic [CountW-1:0]       device_counter;
  } sps_state_t;

endpackage
`default_nettype wire

@@ sv/sps_step.sv @@
// per-tick decision logic: next supervisor state and result word
`default_nettype none
module sps_step
  import sps_pkg::*;
(
  input  sps_state_t st,
  input  sps_cfg_t   cfg,
  input  in_word_t   word,
  output sps_state_t st_nxt,
  output out_word_t  res
);

  logic [StampW-1:0] since_read;
  logic [StampW-1:0] since_conv;
  logic              due;
  logic              conv_done;
  logic              go;
  logic              start;
  logic              probed;
  logic              judged;
  logic              bad;
  logic              taken;
  sps_state_t        s;

  assign since_read = word.now_ms - st.last_read_stamp;
  assign since_conv = word.now_ms - st.conversion_stamp;
  assign due        = st.first_due ||
                      (since_read >= {{(StampW-IntvW){1'b0}}, cfg.read_interval_ms});
  assign conv_done  = since_conv >= {{(StampW-IntvW){1'b0}}, cfg.conversion_ms};
  assign bad        = (word.sample_value < TEMP_LOW_LIMIT) ||
                      (word.sample_value > TEMP_HIGH_LIMIT);

  always_comb begin
    s      = st;
    start  = 1'b0;
    probed = 1'b0;
    judged = 1'b0;
    taken  = 1'b0;
    go     = 1'b1;
    if (!st.converting) begin
      if (due) begin
        if (!st.device_known) begin
          probed           = 1'b1;
          s.device_counter = word.probe_count;
          s.device_known   = word.probe_found;
          if (word.probe_found) begin
            s.error_counter = '0;
          end else begin
            s.last_read_stamp = word.now_ms;
            s.first_due       = 1'b0;
            go                = 1'b0;
          end
        end
        if (go) begin
          start              = 1'b1;
          s.conversion_stamp = word.now_ms;
          s.converting       = 1'b1;
          s.first_due        = 1'b0;
        end
      end
    end else if (conv_done) begin
      judged            = 1'b1;
      s.last_read_stamp = word.now_ms;
      s.converting      = 1'b0;
      if (bad) begin
        if (st.error_counter < ERROR_CEILING) begin
          s.error_counter = st.error_counter + 8'd1;
        end
        if (s.error_counter >= cfg.max_errors) begin
          s.device_known = 1'b0;
          if (st.valid_flag) begin
            s.valid_flag   = 1'b0;
            s.changed_flag = 1'b1;
          end
        end
      end else begin
        s.error_counter = '0;
        if (!st.valid_flag || (word.sample_value != st.held_temperature)) begin
          s.held_temperature = word.sample_value;
          s.valid_flag       = 1'b1;
          s.changed_flag     = 1'b1;
        end
      end
    end
    if (word.take_changed) begin
      taken          = s.changed_flag;
      s.changed_flag = 1'b0;
    end
  end

  assign st_nxt = s;

  always_comb begin
    res.start_conversion = start;
    res.probe_used       = probed;
    res.sample_used      = judged;
    res.temperature      = s.held_temperature;
    res.reading_valid    = s.valid_flag;
    res.changed_taken    = taken;
    res.error_total      = s.error_counter;
    res.device_total     = s.device_counter;
    res.converting       = s.converting;
  end

endmodule
`default_nettype wire

@@ sv/sensor_poll_supervisor.sv @@
// top level of the sensor poll supervisor: word registers, state and config
// One result word per input word, sustained at one word per clock when the
// result side keeps ready high. A word is captured in an input register, runs
// through the tick decision logic in the next cycle and lands in the result
// register together with the state update once that register is empty or being
// drained by out_ready. Config registers (0 read interval, 1 conversion time,
// 2 error limit) are written through cfg_we/cfg_index/cfg_wdata; index 3 is
// ignored. Write them only while no word is in flight.
`default_nettype none
`include "sensor_poll_supervisor_macros.svh"
module sensor_poll_supervisor
  import sps_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire in_word_t   in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output out_word_t       out_data,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [IntvW-1:0] cfg_wdata
);

  localparam logic [1:0] CFG_READ_INTERVAL = 2'd0;
  localparam logic [1:0] CFG_CONVERSION    = 2'd1;
  localparam logic [1:0] CFG_MAX_ERRORS    = 2'd2;

  sps_cfg_t   cfg_r;
  sps_state_t st_r;
  sps_state_t st_nxt;
  in_word_t   in_word_r;
  logic       in_valid_r;
  out_word_t  out_word_r;
  out_word_t  res;
  logic       out_valid_r;
  logic       advance;

  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  sps_step u_step (
    .st     (st_r),
    .cfg    (cfg_r),
    .word   (in_word_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.read_interval_ms <= READ_INTERVAL_RST;
      cfg_r.conversion_ms    <= CONVERSION_RST;
      cfg_r.max_errors       <= MAX_ERRORS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_READ_INTERVAL: cfg_r.read_interval_ms <= cfg_wdata;
        CFG_CONVERSION:    cfg_r.conversion_ms    <= cfg_wdata;
        CFG_MAX_ERRORS:    cfg_r.max_errors       <= cfg_wdata[CountW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.converting       <= 1'b0;
      st_r.device_known     <= 1'b0;
      st_r.first_due        <= 1'b1;
      st_r.last_read_stamp  <= '0;
      st_r.conversion_stamp <= '0;
      st_r.held_temperature <= '0;
      st_r.valid_flag       <= 1'b0;
      st_r.changed_flag     <= 1'b0;
      st_r.error_counter    <= '0;
      st_r.device_counter   <= '0;
      in_valid_r            <= 1'b0;
      out_valid_r           <= 1'b0;
    end else begin
      if (advance) begin
        st_r <= st_nxt;
      end
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_word_r <= in_data;
    end
    if (advance) begin
      out_word_r <= res;
    end
  end

  // input stage holds its word until it moves on
  `SPS_ASSERT(a_in_hold, in_valid_r && !advance |=> in_valid_r && $stable(in_word_r), "input word lost while stalled")
  // a conversion request always leaves the block converting
  `SPS_ASSERT(a_start_conv, out_valid_r && out_word_r.start_conversion |-> out_word_r.converting, "request without converting")
  // judging a sample always returns to idle
  `SPS_ASSERT(a_judge_idle, out_valid_r && out_word_r.sample_used |-> !out_word_r.converting, "judged sample but still converting")
  // a probe that issues no request leaves the block idle
  `SPS_ASSERT(a_probe_fail, out_valid_r && out_word_r.probe_used && !out_word_r.start_conversion |-> !out_word_r.converting, "failed probe left converting")
  // reset empties both word registers
  `SPS_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !in_valid_r && !out_valid_r, "words survive reset")

endmodule
`default_nettype wire
